>>> rtl/core/scir_pkg.sv
// Shared widths, register indexes, field widths and calibration phases for the index remap core.
package scir_pkg;

  localparam int IDX_W     = 32;
  localparam int SPR_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(IDX_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 3'd0,
    REG_SPR    = 3'd1,
    REG_PIN_EN = 3'd2,
    REG_PINNED = 3'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PHASE_NONE   = 2'd0,
    PHASE_ORIGIN = 2'd1,
    PHASE_STRIDE = 2'd2,
    PHASE_SPARE  = 2'd3
  } calib_phase_t;

endpackage

>>> rtl/core/self_calibrating_index_remap_core.sv
// Self-calibrating index remap: origin and stride learning, serial divide, mapping.
//
// One raw index is taken per request transfer (req_valid high, req_stall low)
// and one result leaves per response transfer (rsp_valid high, rsp_stall low),
// carrying the mapped index, the block number and the block offset.
// The first index after reset or a session rewrite becomes the origin, and the
// first later index that differs sets the stride.
// With the stride known, an item passes from request transfer to rsp_valid
// through calibration, the restoring divider (one quotient bit a cycle through
// a single shared subtractor), a multiply step and an add step, and rsp_valid
// is registered on leaving the add step. Before the stride is known the divider
// is skipped. req_stall is high while an item is in flight, so one item is
// handled at a time; a finished result waits in the output register and the
// next item is taken meanwhile, but a new item is never taken before the last
// one has left the add step. A result that meets a stalled output waits in the
// add step until the register is free.
// Configuration writes through cfg_we, cfg_index and cfg_data are taken at
// once and must only come while the block is idle. Writing the schedule base
// or a non-zero slots per round clears calibration.
// A synchronous reset clears calibration, the registers to their defaults and
// the output register; no clearing pass is needed.
module self_calibrating_index_remap_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scir_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [scir_pkg::IDX_W-1:0]       raw_index,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [scir_pkg::IDX_W-1:0]       mapped_index,
  output logic [scir_pkg::IDX_W-1:0]       block_number,
  output logic [scir_pkg::IDX_W-1:0]       block_offset
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CAL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ADD  = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  scir_pkg::calib_phase_t          phase;
  logic [scir_pkg::IDX_W-1:0]      origin;
  logic [scir_pkg::IDX_W-1:0]      stride;
  logic [scir_pkg::IDX_W-1:0]      sched_base;
  logic [scir_pkg::SPR_W-1:0]      slots_per_round;
  logic                            pin_enable;
  logic [scir_pkg::IDX_W-1:0]      pinned_index;
  logic [scir_pkg::IDX_W-1:0]      raw_q;
  logic [scir_pkg::IDX_W-1:0]      quot;
  logic [scir_pkg::IDX_W-1:0]      rem;
  logic [scir_pkg::IDX_W-1:0]      prod;
  logic [scir_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [scir_pkg::IDX_W:0]        sub_a;
  logic [scir_pkg::IDX_W:0]        sub_b;
  logic [scir_pkg::IDX_W+1:0]      sub_res;
  logic                            sub_borrow;
  logic [scir_pkg::IDX_W-1:0]      rel;
  logic [scir_pkg::IDX_W-1:0]      stride_next;
  logic [scir_pkg::IDX_W+scir_pkg::SPR_W-1:0] prod_full;
  logic                            req_xfer;
  logic                            out_free;
  logic                            session_clear;

  assign req_xfer  = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign session_clear = cfg_we && ((cfg_index == scir_pkg::REG_BASE) ||
                         ((cfg_index == scir_pkg::REG_SPR) &&
                          (cfg_data[scir_pkg::SPR_W-1:0] != '0)));

  always_comb begin
    if (state == ST_DIV) begin
      sub_a = {rem, quot[scir_pkg::IDX_W-1]};
      sub_b = {1'b0, stride};
    end else begin
      sub_a = {1'b0, raw_q};
      sub_b = {1'b0, origin};
    end
  end

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[scir_pkg::IDX_W+1];

  always_comb begin
    rel         = (phase == scir_pkg::PHASE_NONE) ? '0 : sub_res[scir_pkg::IDX_W-1:0];
    stride_next = stride;
    if ((phase == scir_pkg::PHASE_ORIGIN) && (rel != '0)) begin
      stride_next = rel;
    end
  end

  assign prod_full = quot * slots_per_round;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = ST_CAL;
        end
      end
      ST_CAL: begin
        state_next = (stride_next == '0) ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == scir_pkg::DIV_CNT_W'(scir_pkg::IDX_W - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_base      <= '0;
      slots_per_round <= scir_pkg::SPR_W'(1);
      pin_enable      <= 1'b0;
      pinned_index    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scir_pkg::REG_BASE: begin
          sched_base <= cfg_data[scir_pkg::IDX_W-1:0];
        end
        scir_pkg::REG_SPR: begin
          if (cfg_data[scir_pkg::SPR_W-1:0] != '0) begin
            slots_per_round <= cfg_data[scir_pkg::SPR_W-1:0];
          end
        end
        scir_pkg::REG_PIN_EN: begin
          pin_enable <= cfg_data[0];
        end
        scir_pkg::REG_PINNED: begin
          pinned_index <= cfg_data[scir_pkg::IDX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || session_clear) begin
      phase  <= scir_pkg::PHASE_NONE;
      origin <= '0;
      stride <= '0;
    end else if (state == ST_CAL) begin
      if (phase == scir_pkg::PHASE_NONE) begin
        origin <= raw_q;
        phase  <= scir_pkg::PHASE_ORIGIN;
      end else if ((phase == scir_pkg::PHASE_ORIGIN) && (rel != '0)) begin
        stride <= stride_next;
        phase  <= scir_pkg::PHASE_STRIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      raw_q <= raw_index;
    end
    case (state)
      ST_CAL: begin
        div_cnt <= '0;
        if (stride_next == '0) begin
          quot <= '0;
          rem  <= rel;
        end else begin
          quot <= rel;
          rem  <= '0;
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + scir_pkg::DIV_CNT_W'(1);
        if (sub_borrow) begin
          rem  <= sub_a[scir_pkg::IDX_W-1:0];
          quot <= {quot[scir_pkg::IDX_W-2:0], 1'b0};
        end else begin
          rem  <= sub_res[scir_pkg::IDX_W-1:0];
          quot <= {quot[scir_pkg::IDX_W-2:0], 1'b1};
        end
      end
      ST_MUL: begin
        prod <= prod_full[scir_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_ADD) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_ADD) && out_free) begin
      mapped_index <= pin_enable ? pinned_index : (sched_base + prod + rem);
      block_number <= quot;
      block_offset <= rem;
    end
  end

endmodule

>>> rtl/core/scir_checker.sv
// Port-level checks on the index remap core, bound to the top level.
module scir_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [scir_pkg::IDX_W-1:0]  mapped_index,
  input logic [scir_pkg::IDX_W-1:0]  block_number,
  input logic [scir_pkg::IDX_W-1:0]  block_offset
);

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Only one item is in flight: a request transfer closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while an item is in flight");

  // A result never appears in the cycle after its request transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !$rose(rsp_valid))
    else $error("response too early after request transfer");

  // A stalled result is held unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(mapped_index) &&
      $stable(block_number) && $stable(block_offset)))
    else $error("stalled response changed");

endmodule

bind self_calibrating_index_remap_core scir_checker u_scir_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .mapped_index (mapped_index),
  .block_number (block_number),
  .block_offset (block_offset)
);

>>> sim/tb_self_calibrating_index_remap_core.sv
// Self-checking testbench for the self-calibrating index remap core.
`timescale 1ns / 100ps

module tb_self_calibrating_index_remap_core;

  localparam int          ITEM_TARGET  = 1550;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 100;
  localparam longint      TIMEOUT_NS   = 6_000_000;

  typedef struct packed {
    logic [scir_pkg::IDX_W-1:0] mapped;
    logic [scir_pkg::IDX_W-1:0] blk;
    logic [scir_pkg::IDX_W-1:0] off;
  } remap_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [scir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scir_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  logic [scir_pkg::IDX_W-1:0]     raw_index = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  logic [scir_pkg::IDX_W-1:0]     mapped_index;
  logic [scir_pkg::IDX_W-1:0]     block_number;
  logic [scir_pkg::IDX_W-1:0]     block_offset;

  // Predictor copy of the registers and of the calibration state.
  logic [scir_pkg::IDX_W-1:0] cfg_base = '0;
  logic [scir_pkg::SPR_W-1:0] cfg_spr = scir_pkg::SPR_W'(1);
  logic                       cfg_pin = 1'b0;
  logic [scir_pkg::IDX_W-1:0] cfg_pinned = '0;
  scir_pkg::calib_phase_t     cal_phase = scir_pkg::PHASE_NONE;
  logic [scir_pkg::IDX_W-1:0] cal_origin = '0;
  logic [scir_pkg::IDX_W-1:0] cal_stride = '0;

  remap_result_t pending_remaps[$];
  remap_result_t oldest_remap;

  logic        out_hold = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_draw;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned pinned_frames = 0;
  int unsigned sessions = 0;

  self_calibrating_index_remap_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .raw_index    (raw_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .mapped_index (mapped_index),
    .block_number (block_number),
    .block_offset (block_offset)
  );

  always #6 clk = ~clk;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(3, 0);
  endfunction

  function automatic void clear_calibration();
    cal_phase  = scir_pkg::PHASE_NONE;
    cal_origin = '0;
    cal_stride = '0;
  endfunction

  function automatic void apply_reg(logic [scir_pkg::CFG_IDX_W-1:0] idx,
                                    logic [scir_pkg::CFG_W-1:0] val);
    case (idx)
      scir_pkg::REG_BASE: begin
        cfg_base = val[scir_pkg::IDX_W-1:0];
        clear_calibration();
      end
      scir_pkg::REG_SPR: begin
        if (val[scir_pkg::SPR_W-1:0] != '0) begin
          cfg_spr = val[scir_pkg::SPR_W-1:0];
          clear_calibration();
        end
      end
      scir_pkg::REG_PIN_EN: cfg_pin = val[0];
      scir_pkg::REG_PINNED: cfg_pinned = val[scir_pkg::IDX_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic remap_result_t predict_remap(logic [scir_pkg::IDX_W-1:0] raw);
    remap_result_t              res;
    logic [scir_pkg::IDX_W-1:0] rel;
    logic [scir_pkg::IDX_W-1:0] spr_wide;
    case (cal_phase)
      scir_pkg::PHASE_NONE: begin
        cal_origin = raw;
        cal_phase  = scir_pkg::PHASE_ORIGIN;
      end
      scir_pkg::PHASE_ORIGIN: begin
        if (raw != cal_origin) begin
          cal_stride = raw - cal_origin;
          cal_phase  = scir_pkg::PHASE_STRIDE;
        end
      end
      default: ;
    endcase
    rel = raw - cal_origin;
    if (cal_stride != '0) begin
      res.blk = rel / cal_stride;
      res.off = rel % cal_stride;
    end else begin
      res.blk = '0;
      res.off = rel;
    end
    spr_wide = scir_pkg::IDX_W'(cfg_spr);
    if (cfg_pin) begin
      res.mapped = cfg_pinned;
      pinned_frames++;
    end else begin
      res.mapped = cfg_base + res.blk * spr_wide + res.off;
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [scir_pkg::IDX_W-1:0] want,
                                      logic [scir_pkg::IDX_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_remaps.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t ns: expected no result, got mapped %h block %h offset %h",
                   $time, mapped_index, block_number, block_offset);
      end else begin
        oldest_remap = pending_remaps.pop_front();
        check_field("mapped_index", oldest_remap.mapped, mapped_index);
        check_field("block_number", oldest_remap.blk, block_number);
        check_field("block_offset", oldest_remap.off, block_offset);
        results_checked++;
      end
    end
  end

  // The receiver holds each result for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (out_hold) begin
      rsp_stall <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rx_draw = draw_wait();
      rx_wait   <= rx_draw;
      rsp_stall <= (rx_draw != 0);
    end else if (rsp_valid && rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      rsp_stall <= (rx_wait > 1);
    end else begin
      rsp_stall <= (rx_wait != 0);
    end
  end

  task automatic send_index(logic [scir_pkg::IDX_W-1:0] raw);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    raw_index <= raw;
    do @(posedge clk); while (req_stall);
    pending_remaps.push_back(predict_remap(raw));
    items_sent++;
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_remaps.size() != 0);
  endtask

  task automatic write_reg(logic [scir_pkg::CFG_IDX_W-1:0] idx,
                           logic [scir_pkg::CFG_W-1:0] val);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
  endtask

  function automatic logic [scir_pkg::IDX_W-1:0] pick_index();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_calibration_basics();
    send_index(32'd100);
    send_index(32'd100);
    send_index(32'd107);
    send_index(32'd138);
    send_index(32'd99);
    send_index(32'd0);
  endtask

  task automatic test_wrap_extremes();
    write_reg(scir_pkg::REG_BASE, 32'hFFFF_FFFF);
    write_reg(scir_pkg::REG_SPR, 32'h0000_FFFF);
    send_index(32'hFFFF_FFFF);
    send_index(32'h0000_0000);
    send_index(32'hFFFF_FFFE);
    // Upper data bits are dropped, so this sets one slot per round.
    write_reg(scir_pkg::REG_SPR, 32'hABCD_0001);
    send_index(32'h0000_0000);
    send_index(32'hFFFF_FFFF);
    send_index(32'h0000_0000);
    send_index(32'hFFFF_FFFE);
  endtask

  task automatic test_pin_mode();
    write_reg(scir_pkg::REG_PINNED, 32'hFFFF_FFFF);
    write_reg(scir_pkg::REG_PIN_EN, 32'hFFFF_FFFF);
    send_index(32'h1234_5678);
    send_index(32'h0000_0000);
    write_reg(scir_pkg::REG_PINNED, 32'h0000_0000);
    send_index(32'hAAAA_5555);
    write_reg(scir_pkg::REG_PIN_EN, 32'hFFFF_FFFE);
    send_index(32'h5555_AAAA);
  endtask

  task automatic test_register_corners();
    write_reg(scir_pkg::REG_SPR, 32'd3);
    send_index(32'h8000_0000);
    write_reg(scir_pkg::REG_SPR, 32'h0000_0000);
    send_index(32'h8000_0010);
    write_reg(scir_pkg::REG_SPR, 32'h0001_0000);
    send_index(32'h8000_0025);
    for (int i = scir_pkg::REG_PINNED + 1; i < (1 << scir_pkg::CFG_IDX_W); i++)
      write_reg(scir_pkg::CFG_IDX_W'(i), $urandom());
    send_index(32'h7FFF_FFFF);
  endtask

  task automatic test_output_hold();
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    no_idle = 1'b1;
    repeat (8) send_index($urandom());
    no_idle = 1'b0;
    wait_drain();
    repeat (4) send_index($urandom());
    wait_drain();
  endtask

  task automatic test_random_sessions();
    logic [scir_pkg::IDX_W-1:0] origin;
    logic [scir_pkg::IDX_W-1:0] stride;
    logic [scir_pkg::IDX_W-1:0] offset;
    logic [scir_pkg::IDX_W-1:0] blk_step;
    logic [scir_pkg::SPR_W-1:0] spr;
    int unsigned                len;
    int unsigned                kind;
    while (items_sent < ITEM_TARGET) begin
      sessions++;
      no_idle = (sessions % 5 == 0);
      write_reg(scir_pkg::REG_BASE, pick_index());
      if ($urandom_range(1, 0) == 1) begin
        case ($urandom_range(4, 0))
          0: spr = scir_pkg::SPR_W'(1);
          1: spr = '1;
          2: spr = scir_pkg::SPR_W'($urandom_range(8, 1));
          default: spr = scir_pkg::SPR_W'($urandom());
        endcase
        write_reg(scir_pkg::REG_SPR, {16'($urandom()), spr});
      end
      if ($urandom_range(3, 0) == 0) begin
        write_reg(scir_pkg::REG_PINNED, pick_index());
        write_reg(scir_pkg::REG_PIN_EN, $urandom());
      end
      case ($urandom_range(5, 0))
        0: stride = $urandom_range(16, 1);
        1: stride = $urandom_range(4096, 1);
        2: stride = 32'd1 << $urandom_range(31, 0);
        3: stride = '1 - $urandom_range(15, 0);
        default: stride = $urandom();
      endcase
      if (stride == '0)
        stride = 1;
      origin = pick_index();
      len = $urandom_range(40, 10);
      send_index(origin);
      repeat ($urandom_range(2, 0)) send_index(origin);
      // Now and then the frame after the origin frames is not a clean stride away.
      if ($urandom_range(9, 0) == 0)
        send_index($urandom());
      else
        send_index(origin + stride);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(9, 0);
        blk_step = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(64, 0);
        offset = $urandom() % stride;
        if (kind < 7)
          send_index(origin + blk_step * stride + offset);
        else if (kind == 7)
          send_index(origin + blk_step * stride);
        else
          send_index($urandom());
        if (i == len / 2 && $urandom_range(5, 0) == 0)
          write_reg(scir_pkg::REG_PIN_EN, $urandom());
        else if ($urandom_range(99, 0) == 0)
          wait_drain();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_calibration_basics();
    test_wrap_extremes();
    test_pin_mode();
    test_register_corners();
    test_output_hold();
    test_random_sessions();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d frames over the directed cases and %0d random sessions,",
             items_sent, sessions);
    $display("with %0d register writes, %0d pinned frames and %0d results checked.",
             reg_writes, pinned_frames, results_checked);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", pending_remaps.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
